@@ hdl/fbc64_pkg.sv @@
// Shared types, constants and functions for the 64-bit Feistel block cipher.
// Holds the substitution table, the key reset values and the round helpers.
// No dependencies.
package fbc64_pkg;

   localparam int unsigned NumRounds = 32;
   localparam int unsigned NumKeys = 8;
   localparam int unsigned RotAmount = 11;

   typedef logic [NumKeys-1:0][31:0] key_set_type;

   typedef enum logic {
      OP_ENCRYPT = 1'b0,
      OP_DECRYPT = 1'b1
   } opcode_type;

   typedef struct packed {
      logic       valid;
      opcode_type opcode;
   } stage_ctl_type;

   localparam key_set_type KEY_RESET = {
      32'h8FFF_FFFF, 32'h7FFF_FFFF, 32'h6FFF_FFFF, 32'h5FFF_FFFF,
      32'h4FFF_FFFF, 32'h3FFF_FFFF, 32'h2FFF_FFFF, 32'h1FFF_FFFF
   };

   localparam logic [3:0] SBOX [8][16] = '{
      '{4'd9, 4'd6, 4'd3, 4'd2, 4'd8, 4'd11, 4'd1, 4'd7,
        4'd10, 4'd4, 4'd14, 4'd15, 4'd12, 4'd0, 4'd13, 4'd5},
      '{4'd3, 4'd7, 4'd14, 4'd9, 4'd8, 4'd10, 4'd15, 4'd0,
        4'd5, 4'd2, 4'd6, 4'd12, 4'd11, 4'd4, 4'd13, 4'd1},
      '{4'd14, 4'd4, 4'd6, 4'd2, 4'd11, 4'd3, 4'd13, 4'd8,
        4'd12, 4'd15, 4'd5, 4'd10, 4'd0, 4'd7, 4'd1, 4'd9},
      '{4'd14, 4'd7, 4'd10, 4'd12, 4'd13, 4'd1, 4'd3, 4'd9,
        4'd0, 4'd2, 4'd11, 4'd4, 4'd15, 4'd8, 4'd5, 4'd6},
      '{4'd11, 4'd5, 4'd1, 4'd9, 4'd8, 4'd13, 4'd15, 4'd0,
        4'd14, 4'd4, 4'd2, 4'd3, 4'd12, 4'd7, 4'd10, 4'd6},
      '{4'd3, 4'd10, 4'd13, 4'd12, 4'd1, 4'd2, 4'd0, 4'd11,
        4'd7, 4'd5, 4'd9, 4'd4, 4'd8, 4'd15, 4'd14, 4'd6},
      '{4'd1, 4'd13, 4'd2, 4'd9, 4'd7, 4'd10, 4'd6, 4'd0,
        4'd8, 4'd12, 4'd4, 4'd5, 4'd15, 4'd3, 4'd11, 4'd14},
      '{4'd11, 4'd10, 4'd15, 4'd5, 4'd0, 4'd12, 4'd14, 4'd8,
        4'd6, 4'd2, 4'd3, 4'd9, 4'd1, 4'd7, 4'd13, 4'd4}
   };

   function automatic logic [2:0] key_index(opcode_type opcode, logic [4:0] round_idx);
      logic forward;
      forward = (opcode == OP_ENCRYPT) ? (round_idx < 5'd24) : (round_idx < 5'd8);
      return forward ? round_idx[2:0] : ~round_idx[2:0];
   endfunction

   function automatic logic [31:0] round_fn(logic [31:0] half, logic [31:0] key);
      logic [31:0] sum;
      logic [31:0] sub;
      sum = half + key;
      for (int j = 0; j < 8; j++) begin
         sub[4*j +: 4] = SBOX[j][sum[4*j +: 4]];
      end
      return {sub[31-RotAmount:0], sub[31:32-RotAmount]};
   endfunction

endpackage

@@ hdl/fbc64_csr.sv @@
// Key register file behind the APB-style configuration port.
// Depends on fbc64_pkg for the key set type and reset values.
module fbc64_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [4:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output fbc64_pkg::key_set_type keys
);
   import fbc64_pkg::*;

   key_set_type key_ff;
   key_set_type key_in;
   logic        wr_en;

   assign wr_en = psel && penable && pwrite;

   always_comb begin
      key_in = key_ff;
      if (wr_en) begin
         key_in[paddr[4:2]] = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= KEY_RESET;
      end else begin
         key_ff <= key_in;
      end
   end

   assign prdata = key_ff[paddr[4:2]];
   assign pready = 1'b1;
   assign keys   = key_ff;

endmodule

@@ hdl/fbc64_cell.sv @@
// One round cell of the cipher chain: a Feistel round and its stage register.
// Depends on fbc64_pkg for the round function, key selection and stage types.
module fbc64_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [4:0]              round_idx,
   input  fbc64_pkg::key_set_type  keys,
   input  fbc64_pkg::stage_ctl_type up_ctl,
   input  logic [31:0]             up_left,
   input  logic [31:0]             up_right,
   output logic                    up_ready,
   input  logic                    dn_ready,
   output fbc64_pkg::stage_ctl_type dn_ctl,
   output logic [31:0]             dn_left,
   output logic [31:0]             dn_right
);
   import fbc64_pkg::*;

   stage_ctl_type ctl_ff;
   logic [31:0]   left_ff;
   logic [31:0]   right_ff;
   logic [31:0]   left_in;
   logic [31:0]   right_in;
   logic [31:0]   round_key;

   assign up_ready  = !ctl_ff.valid || dn_ready;
   assign round_key = keys[key_index(up_ctl.opcode, round_idx)];
   assign left_in   = up_right;
   assign right_in  = up_left ^ round_fn(up_right, round_key);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (up_ready) begin
         ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_ctl.valid) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign dn_ctl   = ctl_ff;
   assign dn_left  = left_ff;
   assign dn_right = right_ff;

endmodule

@@ hdl/feistel_block_cipher_64.sv @@
// Top level of the 64-bit Feistel block cipher in codebook mode.
// Depends on fbc64_pkg, fbc64_csr and fbc64_cell.
//
// Each word entering on the req channel runs through a chain of 32 round
// cells, one register stage per round, and leaves on the rsp channel. A new
// word is accepted in every cycle unless req_stall is high; a stall on the
// rsp side holds the words in the chain and fills empty stages before it
// holds the input. The 256-bit key is eight 32-bit registers at byte addresses
// 0x00 to 0x1C and should be written only while no word is in flight.
module feistel_block_cipher_64 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [63:0] req_block_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_block_out,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import fbc64_pkg::*;

   key_set_type   keys;
   stage_ctl_type ctl   [NumRounds+1];
   logic [31:0]   left  [NumRounds+1];
   logic [31:0]   right [NumRounds+1];
   logic          ready [NumRounds+1];

   fbc64_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .keys    (keys)
   );

   assign ctl[0].valid  = req_valid;
   assign ctl[0].opcode = opcode_type'(req_opcode);
   assign left[0]       = req_block_in[63:32];
   assign right[0]      = req_block_in[31:0];
   assign req_stall     = !ready[0];

   for (genvar i = 0; i < NumRounds; i++) begin : g_round
      fbc64_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .round_idx (5'(i)),
         .keys      (keys),
         .up_ctl    (ctl[i]),
         .up_left   (left[i]),
         .up_right  (right[i]),
         .up_ready  (ready[i]),
         .dn_ready  (ready[i+1]),
         .dn_ctl    (ctl[i+1]),
         .dn_left   (left[i+1]),
         .dn_right  (right[i+1])
      );
   end

   // Every cell swaps the halves, so the final swap is undone here.
   assign ready[NumRounds] = !rsp_stall;
   assign rsp_valid        = ctl[NumRounds].valid;
   assign rsp_block_out    = {right[NumRounds], left[NumRounds]};

endmodule
